/* rtl/core/gspg_pkg.sv */
// Shared types, constants and the exp(-t) table builder for the Gaussian spot pixel generator.
package gspg_pkg;

  // Item field widths
  localparam int MODE_BITS   = 2;
  localparam int INDEX_BITS  = 4;
  localparam int FIELD_COORD = 13;
  localparam int W_BITS      = 24;
  localparam int H_BITS      = 32;
  localparam int FRAME_BITS  = 32;
  localparam int PIX_BITS    = 32;

  // Input tdata layout, lowest bit first
  localparam int IN_DATA_W   = 144;
  localparam int OFF_IDX     = 0;
  localparam int OFF_PX      = 4;
  localparam int OFF_PY      = 17;
  localparam int OFF_W       = 30;
  localparam int OFF_H       = 54;
  localparam int OFF_BX      = 86;
  localparam int OFF_BY      = 99;
  localparam int OFF_FRAME   = 112;

  // Configuration
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BIN   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GROW  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT = 2'd3;

  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;

  // Width term and divider
  localparam int M_BITS = 18;
  localparam int E_BITS = 6;
  localparam int K_BITS = 34;
  localparam logic [K_BITS-1:0] GAUSS_K = 34'h2C5C85FDF; // 4*ln2 in Q32
  localparam int DEN_BITS = 2 * W_BITS;

  // Exp table
  localparam int EXP_DEPTH      = 1024;
  localparam int EXP_DEPTH_LOG2 = 10;
  localparam int EXP_RANGE      = 16;
  localparam int T_BITS         = 20; // t below EXP_RANGE in Q16
  localparam int EXP_BITS       = 17;

  // Accumulation and scaling
  localparam int SUM_BITS     = 48;
  localparam int CONTRIB_BITS = H_BITS + EXP_BITS;
  localparam int GF_BITS      = W_BITS + FRAME_BITS;
  localparam int SCALE_BITS   = GF_BITS + 1;
  localparam int SUM_CHUNK    = 24;
  localparam int SCALE_CHUNK  = 19;
  localparam int PP_BITS      = SUM_CHUNK + SCALE_CHUNK;
  localparam int BIG_BITS     = SUM_BITS + SCALE_BITS;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_PIXEL = 2'd1,
    MODE_FRAME = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LD_SQ,
    ST_LD_DIV,
    ST_LD_WRITE,
    ST_PX_SCALE,
    ST_T_ADDR,
    ST_T_D2,
    ST_T_PROD,
    ST_T_LOOKUP,
    ST_T_MUL,
    ST_T_ACC,
    ST_PX_PP,
    ST_PX_PPACC,
    ST_PX_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic frame_set;
    logic den_mul;
    logic div_step;
    logic peak_write;
    logic scale_start;
    logic ram_read;
    logic d2;
    logic prod;
    logic lookup;
    logic contrib;
    logic accum;
    logic pp_mul;
    logic pp_acc;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_ok;
    logic       w_zero;
    logic       div_done;
    logic       no_terms;
    logic       last_term;
    logic       pp_last;
    logic       out_stall;
  } dp_status_t;

  typedef logic [EXP_BITS-1:0] exp_rom_t [EXP_DEPTH];

  // Shift-and-subtract quotient, used only while the table is built
  function automatic longint unsigned long_quot(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // exp(-i*RANGE/DEPTH) in Q16: Q30 base from a truncated Taylor series,
  // powered up with round-half-up, then rounded to Q16.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t        r;
    longint unsigned term;
    longint unsigned base;
    longint unsigned p;
    term = 64'd1 << 30;
    base = term;
    p    = 64'd1 << 30;
    for (int n = 1; n <= 24; n++) begin
      term = long_quot(term * 64'(EXP_RANGE), 64'(EXP_DEPTH * n));
      if ((n % 2) == 1) base = base - term;
      else              base = base + term;
    end
    r[0] = 17'd65536;
    for (int i = 1; i < EXP_DEPTH; i++) begin
      p    = (p * base + (64'd1 << 29)) >> 30;
      r[i] = EXP_BITS'((p + (64'd1 << 13)) >> 14);
    end
    return r;
  endfunction

endpackage

/* rtl/core/gaussian_spot_pixel_generator_unit.sv */
// Top level of the Gaussian spot pixel generator: controller, datapath and checks.
//
//  Channel  Direction  Handshake           Carries
//  s_*      in         s_tvalid/s_tready   load-peak, pixel and set-frame items
//  m_*      out        m_tvalid/m_tready   one pixel per pixel item
//  cfg_*    in         cfg_we              register writes, no read-back
//
// A load-peak item uses the width divider, which runs one
// quotient bit a cycle until 18 significant bits are in.
// A zero-width peak skips the divider.
// A pixel item evaluates T terms, T = active peaks times sub-pixels
// (1 or 4); each term walks the single table read port, one multiplier stage
// per step and the exp ROM. The final scaling takes six 24x19 partial products.
// rst is synchronous; the peak table is not cleared. A stalled result holds in
// the output register while the next item is taken; a finished pixel waits only
// when that register is still full.
module gaussian_spot_pixel_generator_unit
  import gspg_pkg::*;
#(
  parameter int MAX_PEAKS  = 16,
  parameter int COORD_BITS = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // peak_index, peak_x, peak_y, peak_width, peak_height, pixel_x, pixel_y, frame_number
  input  logic [IN_DATA_W-1:0]     s_tdata,
  // mode
  input  logic [MODE_BITS-1:0]     s_tuser,
  input  logic                     s_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // pixel_value
  output logic [PIX_BITS-1:0]      m_tdata,
  // saturated
  output logic                     m_tuser
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // Sequence each item through the shared datapath
  gspg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Hold the table, divider, term unit, scaler and output register
  gspg_datapath #(
    .MAX_PEAKS  (MAX_PEAKS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .st        (st)
  );

  // Drop ready for at least the decode cycle after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  // A clipped pixel is always all ones in its low byte
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:0] == 8'hFF)
    else $error("saturated pixel not at depth maximum");

  // Write the table only for an index inside it
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.peak_write |-> st.idx_ok)
    else $error("peak table written out of range");

  // Load a result only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !st.out_stall)
    else $error("pending result overwritten");

endmodule

/* rtl/core/gspg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gspg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/gspg_ctrl.sv */
// Controller state machine: sequences peak loads, per-term evaluation and output scaling.
module gspg_ctrl
  import gspg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (st.mode)
          MODE_LOAD: begin
            if (!st.idx_ok)     state_next = ST_IDLE;
            else if (st.w_zero) state_next = ST_LD_WRITE;
            else                state_next = ST_LD_SQ;
          end
          MODE_PIXEL: state_next = ST_PX_SCALE;
          MODE_FRAME: begin
            cmd.frame_set = 1'b1;
            state_next    = ST_IDLE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_LD_SQ: begin
        cmd.den_mul = 1'b1;
        state_next  = ST_LD_DIV;
      end
      ST_LD_DIV: begin
        if (st.div_done) state_next = ST_LD_WRITE;
        else             cmd.div_step = 1'b1;
      end
      ST_LD_WRITE: begin
        cmd.peak_write = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_PX_SCALE: begin
        cmd.scale_start = 1'b1;
        state_next      = st.no_terms ? ST_PX_PP : ST_T_ADDR;
      end
      ST_T_ADDR: begin
        cmd.ram_read = 1'b1;
        state_next   = ST_T_D2;
      end
      ST_T_D2: begin
        cmd.d2     = 1'b1;
        state_next = ST_T_PROD;
      end
      ST_T_PROD: begin
        cmd.prod   = 1'b1;
        state_next = ST_T_LOOKUP;
      end
      ST_T_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_T_MUL;
      end
      ST_T_MUL: begin
        cmd.contrib = 1'b1;
        state_next  = ST_T_ACC;
      end
      ST_T_ACC: begin
        cmd.accum  = 1'b1;
        state_next = st.last_term ? ST_PX_PP : ST_T_ADDR;
      end
      ST_PX_PP: begin
        cmd.pp_mul = 1'b1;
        state_next = ST_PX_PPACC;
      end
      ST_PX_PPACC: begin
        cmd.pp_acc = 1'b1;
        state_next = st.pp_last ? ST_PX_OUT : ST_PX_PP;
      end
      ST_PX_OUT: begin
        if (!st.out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/gspg_datapath.sv */
// Datapath: configuration, peak table, width divider, term unit, scaling and output register.
module gspg_datapath
  import gspg_pkg::*;
#(
  parameter int MAX_PEAKS  = 16,
  parameter int COORD_BITS = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]     s_tdata,
  input  logic [MODE_BITS-1:0]     s_tuser,
  input  logic                     s_tlast,
  input  logic                     m_tready,
  output logic                     m_tvalid,
  output logic [PIX_BITS-1:0]      m_tdata,
  output logic                     m_tuser,
  input  dp_cmd_t                  cmd,
  output dp_status_t               st
);

  localparam int AW      = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int KW      = $clog2(MAX_PEAKS + 1);
  localparam int CW      = COORD_BITS;
  localparam int UW      = CW + 1;
  localparam int SQW     = 2 * UW;
  localparam int D2W     = SQW + 1;
  localparam int PW      = D2W + M_BITS;
  localparam int SW      = PW + 16;
  localparam int ENTRY_W = 2 * CW + H_BITS + E_BITS + M_BITS;

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  // Configuration registers
  logic                bin_by_two;
  logic [1:0]          pixel_depth;
  logic [W_BITS-1:0]   growth_step;
  logic [4:0]          peak_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_by_two  <= 1'b0;
      pixel_depth <= DEPTH_16;
      growth_step <= '0;
      peak_count  <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIN:   bin_by_two  <= cfg_data[0];
        CFG_DEPTH: pixel_depth <= cfg_data[1:0];
        CFG_GROW:  growth_step <= cfg_data;
        CFG_COUNT: peak_count  <= cfg_data[4:0];
        default:   bin_by_two  <= bin_by_two;
      endcase
    end
  end

  // Captured item
  logic [1:0]            mode_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic [CW-1:0]         px_q, py_q, bx_q, by_q;
  logic [W_BITS-1:0]     w_q;
  logic [H_BITS-1:0]     h_q;
  logic                  eof_q;
  logic [FRAME_BITS-1:0] fnum_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= s_tuser;
      idx_q  <= s_tdata[OFF_IDX +: INDEX_BITS];
      px_q   <= CW'(s_tdata[OFF_PX +: FIELD_COORD]);
      py_q   <= CW'(s_tdata[OFF_PY +: FIELD_COORD]);
      w_q    <= s_tdata[OFF_W +: W_BITS];
      h_q    <= s_tdata[OFF_H +: H_BITS];
      bx_q   <= CW'(s_tdata[OFF_BX +: FIELD_COORD]);
      by_q   <= CW'(s_tdata[OFF_BY +: FIELD_COORD]);
      fnum_q <= s_tdata[OFF_FRAME +: FRAME_BITS];
      eof_q  <= s_tlast;
    end
  end

  // Frame counter
  logic [FRAME_BITS-1:0] frame_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= '0;
    end else if (cmd.frame_set) begin
      frame_counter <= fnum_q;
    end else if (cmd.out_load && eof_q) begin
      frame_counter <= frame_counter + 1'b1;
    end
  end

  // Width divider: bits of K * 2^48 / w^2, keeping 18 bits from the leading one
  logic [DEN_BITS-1:0] den, rem;
  logic [K_BITS-1:0]   dsh;
  logic [6:0]          step;
  logic                dstarted;
  logic [M_BITS-1:0]   dm;
  logic [E_BITS-1:0]   de;
  logic [4:0]          dcnt;
  logic                div_done;
  logic [DEN_BITS:0]   rem_sh;
  logic                ge;

  assign rem_sh = {rem, dsh[K_BITS-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.den_mul) begin
      den      <= DEN_BITS'(w_q) * DEN_BITS'(w_q);
      rem      <= '0;
      dsh      <= GAUSS_K;
      step     <= '0;
      dstarted <= 1'b0;
      dm       <= '0;
      de       <= '0;
      dcnt     <= '0;
      div_done <= 1'b0;
    end else if (cmd.div_step) begin
      rem  <= ge ? DEN_BITS'(rem_sh - {1'b0, den}) : rem_sh[DEN_BITS-1:0];
      dsh  <= {dsh[K_BITS-2:0], 1'b0};
      step <= step + 1'b1;
      if (!dstarted) begin
        if (ge) begin
          dstarted <= 1'b1;
          dm       <= M_BITS'(1);
          de       <= step[E_BITS-1:0];
          dcnt     <= 5'd1;
        end
      end else begin
        dm   <= {dm[M_BITS-2:0], ge};
        dcnt <= dcnt + 1'b1;
        if (dcnt == 5'(M_BITS - 1)) div_done <= 1'b1;
      end
    end
  end

  // Peak table
  logic                 w_zero;
  logic [ENTRY_W-1:0]   wr_entry, rdata;
  logic [KW-1:0]        k;
  logic [1:0]           sp;

  assign w_zero   = (w_q == '0);
  assign wr_entry = {px_q, py_q, h_q,
                     (w_zero ? {E_BITS{1'b0}} : de), (w_zero ? {M_BITS{1'b0}} : dm)};

  gspg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PEAKS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.peak_write),
    .waddr (AW'(idx_q)),
    .wdata (wr_entry),
    .re    (cmd.ram_read),
    .raddr (k[AW-1:0]),
    .rdata (rdata)
  );

  logic [CW-1:0]     rd_px, rd_py;
  logic [H_BITS-1:0] rd_h;
  logic [E_BITS-1:0] rd_e;
  logic [M_BITS-1:0] rd_m;

  assign {rd_px, rd_py, rd_h, rd_e, rd_m} = rdata;

  // Term unit
  logic [UW-1:0]  ux, uy, dx, dy;
  logic [SQW-1:0] sqx, sqy;
  logic [D2W-1:0] d2;
  logic [PW-1:0]  prod;
  logic [SW-1:0]  tsh;
  logic [EXP_BITS-1:0]     exp_q;
  logic                    term_en;
  logic [CONTRIB_BITS-1:0] contrib;
  logic [SUM_BITS-1:0]     acc;
  logic [SUM_BITS+1:0]     acc_sum;

  assign ux  = bin_by_two ? {bx_q, sp[0]} : {1'b0, bx_q};
  assign uy  = bin_by_two ? {by_q, sp[1]} : {1'b0, by_q};
  assign dx  = (ux >= {1'b0, rd_px}) ? ux - {1'b0, rd_px} : {1'b0, rd_px} - ux;
  assign dy  = (uy >= {1'b0, rd_py}) ? uy - {1'b0, rd_py} : {1'b0, rd_py} - uy;
  assign sqx = SQW'(dx) * SQW'(dx);
  assign sqy = SQW'(dy) * SQW'(dy);
  assign tsh = (rd_e >= 6'd16) ? (SW'(prod) >> (rd_e - 6'd16))
                               : (SW'(prod) << (6'd16 - rd_e));
  assign acc_sum = (SUM_BITS+2)'(acc) + (SUM_BITS+2)'(contrib);

  // Loop bounds
  logic [KW-1:0] cnt_eff;
  logic [1:0]    sp_last;
  logic          k_last;

  assign cnt_eff = (int'(peak_count) > MAX_PEAKS) ? KW'(MAX_PEAKS) : KW'(peak_count);
  assign sp_last = bin_by_two ? 2'd3 : 2'd0;
  assign k_last  = (({1'b0, k} + 1'b1) == {1'b0, cnt_eff});

  // Output scaling
  logic [GF_BITS-1:0]    gf_prod;
  logic [SCALE_BITS-1:0] scale;
  logic                  pi;
  logic [1:0]            pj;
  logic [SUM_CHUNK-1:0]  pa;
  logic [SCALE_CHUNK-1:0] pb;
  logic [6:0]            poff, poff_q;
  logic [PP_BITS-1:0]    pp;
  logic [BIG_BITS-1:0]   pbig;

  assign scale = SCALE_BITS'(gf_prod) + SCALE_BITS'(65536);
  assign pa    = pi ? acc[2*SUM_CHUNK-1:SUM_CHUNK] : acc[SUM_CHUNK-1:0];

  always_comb begin
    case (pj)
      2'd0:    begin pb = scale[SCALE_CHUNK-1:0];               poff = 7'd0;  end
      2'd1:    begin pb = scale[2*SCALE_CHUNK-1:SCALE_CHUNK];   poff = 7'(SCALE_CHUNK); end
      2'd2:    begin pb = scale[3*SCALE_CHUNK-1:2*SCALE_CHUNK]; poff = 7'(2*SCALE_CHUNK); end
      default: begin pb = '0;                                   poff = 7'd0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.scale_start) begin
      gf_prod <= GF_BITS'(growth_step) * GF_BITS'(frame_counter);
      acc     <= '0;
      k       <= '0;
      sp      <= '0;
      pbig    <= '0;
      pi      <= 1'b0;
      pj      <= '0;
    end
    if (cmd.d2) begin
      d2 <= D2W'(sqx) + D2W'(sqy);
    end
    if (cmd.prod) begin
      prod <= PW'(d2) * PW'(rd_m);
    end
    if (cmd.lookup) begin
      exp_q   <= EXP_ROM[tsh[T_BITS-1 -: EXP_DEPTH_LOG2]];
      term_en <= (tsh[SW-1:T_BITS] == '0) && (rd_m != '0);
    end
    if (cmd.contrib) begin
      contrib <= term_en ? CONTRIB_BITS'(rd_h) * CONTRIB_BITS'(exp_q) : '0;
    end
    if (cmd.accum) begin
      // Saturate as the sum goes; terms are never negative
      acc <= (acc_sum[SUM_BITS+1:SUM_BITS] != 2'b00) ? {SUM_BITS{1'b1}}
                                                     : acc_sum[SUM_BITS-1:0];
      if (k_last) begin
        k  <= '0;
        sp <= sp + 1'b1;
      end else begin
        k <= k + 1'b1;
      end
    end
    if (cmd.pp_mul) begin
      pp     <= PP_BITS'(pa) * PP_BITS'(pb);
      poff_q <= poff + (pi ? 7'(SUM_CHUNK) : 7'd0);
    end
    if (cmd.pp_acc) begin
      pbig <= pbig + (BIG_BITS'(pp) << poff_q);
      if (pj == 2'd2) begin
        pj <= '0;
        pi <= ~pi;
      end else begin
        pj <= pj + 1'b1;
      end
    end
  end

  // Output register
  logic [PIX_BITS-1:0] maxv, v;
  logic                over;

  always_comb begin
    case (pixel_depth)
      DEPTH_8:  maxv = 32'h0000_00FF;
      DEPTH_16: maxv = 32'h0000_FFFF;
      default:  maxv = 32'hFFFF_FFFF;
    endcase
  end

  assign v    = pbig[2*PIX_BITS-1:PIX_BITS];
  assign over = (pbig[BIG_BITS-1:2*PIX_BITS] != '0) || (v > maxv);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= over ? maxv : v;
      m_tuser <= over;
    end
  end

  // Status
  assign st.mode      = mode_q;
  assign st.idx_ok    = int'(idx_q) < MAX_PEAKS;
  assign st.w_zero    = w_zero;
  assign st.div_done  = div_done;
  assign st.no_terms  = (cnt_eff == '0);
  assign st.last_term = k_last && (sp == sp_last);
  assign st.pp_last   = pi && (pj == 2'd2);
  assign st.out_stall = m_tvalid && !m_tready;

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the Gaussian spot pixel generator.
module tb_top;
  import gspg_pkg::*;

  localparam int NPEAK = 16;
  localparam int CB    = 13;
  localparam longint unsigned KQ = 64'd11908177887;

  typedef struct packed {
    logic [1:0]   mode;
    logic [3:0]   idx;
    logic [12:0]  px;
    logic [12:0]  py;
    logic [23:0]  w;
    logic [31:0]  h;
    logic [12:0]  bx;
    logic [12:0]  by;
    logic         eof;
    logic [31:0]  frame;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } pixel_t;

  typedef struct {
    logic       is_cfg;
    logic [1:0] reg_idx;
    logic [23:0] reg_val;
    int         hold;   // 1 = wait until idle before this entry
    item_t      it;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [MODE_BITS-1:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [PIX_BITS-1:0] m_tdata;
  logic m_tuser;

  gaussian_spot_pixel_generator_unit u_dut (.*);

  always #2 clk = ~clk;

  // predictor state
  exp_rom_t              exp_q16;
  logic [25:0]           spot_pos [NPEAK];
  logic [55:0]           spot_shape [NPEAK];
  logic [31:0]           frame_cnt;
  logic                  cfg_bin;
  logic [1:0]            cfg_depth;
  logic [23:0]           cfg_grow;
  logic [4:0]            cfg_count;

  job_t   pending[$];
  pixel_t pixels_due[$];
  int     errors = 0;
  int     pixels_seen = 0;
  int     sent = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  logic   stim_done = 1'b0;
  int     idle_wait = 0;

  // floor(K*2^(e-16)/w^2) packed as e<<18 | m
  function automatic logic [23:0] spot_width_code(logic [23:0] w);
    longint unsigned den, q, r;
    int s, e;
    if (w == 0) return 24'd0;
    den = longint'(w) * longint'(w);
    q = KQ / den;
    r = KQ % den;
    s = 0;
    while (q >= (64'd1 << 18)) begin
      q >>= 1;
      s--;
    end
    while (q < (64'd1 << 17) && s < 47) begin
      r <<= 1;
      q <<= 1;
      if (r >= den) begin
        r -= den;
        q |= 64'd1;
      end
      s++;
    end
    e = 16 + s;
    if (e < 0) e = 0;
    if (e > 63) e = 63;
    return {e[5:0], q[17:0]};
  endfunction

  function automatic longint unsigned spot_term(int k, longint unsigned ux,
                                                longint unsigned uy);
    longint unsigned m, h, px, py, dx, dy, prod, t;
    int e, sh;
    m  = 64'(spot_shape[k][17:0]);
    e  = int'(spot_shape[k][23:18]);
    h  = 64'(spot_shape[k][55:24]);
    px = 64'(spot_pos[k][2*CB-1:CB]);
    py = 64'(spot_pos[k][CB-1:0]);
    dx = ux > px ? ux - px : px - ux;
    dy = uy > py ? uy - py : py - uy;
    if (m == 0) return 0;
    prod = (dx * dx + dy * dy) * m;
    if (e >= 16) t = prod >> (e - 16);
    else begin
      sh = 16 - e;
      if (prod >= (64'd1 << (63 - sh))) return 0;
      t = prod << sh;
    end
    if (t >= (64'd16 << 16)) return 0;
    return h * 64'(exp_q16[(t * 1024) / (64'd16 << 16)]);
  endfunction

  // apply one accepted item to the predictor; return 1 with a pixel if one is due
  function automatic bit predict_pixel(item_t it, output pixel_t px_out);
    longint unsigned sum, scale, maxv, v;
    int cnt, n;
    bit over;
    px_out = '0;
    if (it.mode == MODE_LOAD) begin
      spot_pos[it.idx]   = {it.px, it.py};
      spot_shape[it.idx] = {it.h, spot_width_code(it.w)};
      return 0;
    end
    if (it.mode == MODE_FRAME) begin
      frame_cnt = it.frame;
      return 0;
    end
    if (it.mode != MODE_PIXEL) return 0;
    cnt = int'(cfg_count) > NPEAK ? NPEAK : int'(cfg_count);
    n = cfg_bin ? 2 : 1;
    sum = 0;
    for (int sy = 0; sy < n; sy++)
      for (int sx = 0; sx < n; sx++)
        for (int k = 0; k < cnt; k++)
          sum += spot_term(k, longint'(it.bx) * n + sx, longint'(it.by) * n + sy);
    if (sum > 64'hFFFF_FFFF_FFFF) sum = 64'hFFFF_FFFF_FFFF;
    scale = 65536 + longint'(cfg_grow) * longint'(frame_cnt);
    maxv = cfg_depth == DEPTH_8 ? 64'hFF : cfg_depth == DEPTH_16 ? 64'hFFFF : 64'hFFFF_FFFF;
    over = 0;
    v = 0;
    if (sum != 0 && sum > 64'hFFFF_FFFF_FFFF_FFFF / scale) over = 1;
    else begin
      v = (sum * scale) >> 32;
      if (v > maxv) over = 1;
    end
    px_out.value = over ? maxv[31:0] : v[31:0];
    px_out.sat   = over;
    if (it.eof) frame_cnt = frame_cnt + 32'd1;
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic item_t rand_item(int mode);
    item_t it;
    it = '0;
    it.mode  = 2'(mode);
    it.idx   = 4'($urandom_range(0, 15));
    it.px    = 13'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40));
    it.py    = 13'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40));
    case ($urandom_range(0, 3))
      0: it.w = 24'($urandom);
      1: it.w = 24'($urandom_range(0, 32'h2000));
      default: it.w = 24'($urandom_range(32'h100, 32'h1000));
    endcase
    it.h     = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 5000);
    it.bx    = 13'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 24));
    it.by    = 13'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 24));
    it.eof   = $urandom_range(0, 7) == 0;
    it.frame = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 10);
    return it;
  endfunction

  function automatic void push_item(item_t it, int hold);
    job_t j;
    j.is_cfg = 0; j.reg_idx = '0; j.reg_val = '0; j.hold = hold; j.it = it;
    pending = {pending, j};
  endfunction

  function automatic void push_cfg(logic [1:0] idx, logic [23:0] val);
    job_t j;
    j.is_cfg = 1; j.reg_idx = idx; j.reg_val = val; j.hold = 1; j.it = '0;
    pending = {pending, j};
  endfunction

  // Driver: register writes only after the block has drained; items otherwise.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_we   <= 1'b0;
    end else begin
      logic cfg_pulse;
      cfg_pulse = 1'b0;
      if (s_tvalid && s_tready) sent++;
      if (!s_tvalid || s_tready) begin
        if (pending.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (pending[0].hold != 0 &&
                     (pixels_due.size() != 0 || (s_tvalid && s_tready))) begin
          s_tvalid <= 1'b0;
          idle_wait <= 0;
        end else if (pending[0].hold != 0 && idle_wait < 200) begin
          // let a load still in flight finish before touching registers
          s_tvalid <= 1'b0;
          idle_wait <= idle_wait + 1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          s_tvalid <= 1'b0;
        end else begin
          job_t j;
          j = pending.pop_front();
          idle_wait <= 0;
          if (j.is_cfg) begin
            s_tvalid  <= 1'b0;
            cfg_pulse = 1'b1;
            cfg_index <= j.reg_idx;
            cfg_data  <= j.reg_val;
            case (j.reg_idx)
              CFG_BIN:   cfg_bin   = j.reg_val[0];
              CFG_DEPTH: cfg_depth = j.reg_val[1:0];
              CFG_GROW:  cfg_grow  = j.reg_val;
              default:   cfg_count = j.reg_val[4:0];
            endcase
          end else begin
            pixel_t p;
            s_tvalid <= 1'b1;
            s_tuser  <= j.it.mode;
            s_tlast  <= j.it.eof;
            s_tdata  <= {j.it.frame, j.it.by, j.it.bx, j.it.h, j.it.w,
                         j.it.py, j.it.px, j.it.idx};
            // predict at hand-over: the item is accepted before any later one
            if (predict_pixel(j.it, p)) pixels_due = {pixels_due, p};
          end
        end
      end
      cfg_we   <= cfg_pulse;
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: compare each pixel transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      pixels_seen++;
      if (pixels_due.size() == 0) begin
        report_mismatch("unexpected pixel", m_tdata, 32'h0);
      end else begin
        pixel_t want;
        want = pixels_due.pop_front();
        if (m_tdata !== want.value) report_mismatch("pixel_value", m_tdata, want.value);
        if (m_tuser !== want.sat) report_mismatch("saturated", {31'd0, m_tuser}, {31'd0, want.sat});
      end
    end
  end

  task automatic add_random_phase(int count);
    // phase knobs change only once the queue reaches this point
    for (int i = 0; i < count; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        item_t it;
        it = rand_item(MODE_LOAD);
        it.idx = 4'($urandom_range(0, 3));
        push_item(it, 0);
      end else if (r < 90) push_item(rand_item(MODE_PIXEL), 0);
      else if (r < 96) push_item(rand_item(MODE_FRAME), 0);
      else push_item(rand_item(3), 0);
    end
  endtask

  initial begin
    item_t it;
    exp_q16 = build_exp_rom();
    frame_cnt = '0; cfg_bin = 1'b0; cfg_depth = DEPTH_16; cfg_grow = '0; cfg_count = 5'd1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: fill every table entry, then the extremes
    for (int k = 0; k < NPEAK; k++) begin
      it = rand_item(MODE_LOAD);
      it.idx = 4'(k);
      it.px = 13'(10 + k); it.py = 13'd12; it.w = 24'h300; it.h = 32'(1000 + k);
      if (k == 1) it.w = 24'd0;                   // zero width peak
      if (k == 2) begin it.px = 13'h1FFF; it.py = 13'h1FFF; it.w = 24'hFFFFFF;
                  it.h = 32'hFFFFFFFF; end
      if (k == 3) it.w = 24'd1;                   // very narrow peak
      push_item(it, 0);
    end
    it = rand_item(MODE_PIXEL); it.bx = 13'd10; it.by = 13'd12; it.eof = 1'b0;
    push_item(it, 0);
    push_cfg(CFG_COUNT, 24'd31);                 // count above the table size
    push_cfg(CFG_DEPTH, 24'd0);
    it.bx = 13'h1FFF; it.by = 13'h1FFF; push_item(it, 1);
    it.bx = 13'd3000; it.by = 13'd0; push_item(it, 0);   // far from every peak
    push_cfg(CFG_DEPTH, 24'd3);                  // unused depth code
    push_cfg(CFG_GROW, 24'hFFFFFF);
    push_cfg(CFG_BIN, 24'd1);
    it = rand_item(MODE_FRAME); it.frame = 32'hFFFFFFFF; push_item(it, 1);
    it = rand_item(MODE_PIXEL); it.bx = 13'd6; it.by = 13'd6; it.eof = 1'b1;
    push_item(it, 0);                            // scaling overflow, counter wraps
    it = rand_item(3); push_item(it, 0);          // unused mode
    it.eof = 1'b0; it.mode = MODE_PIXEL; it.bx = 13'd5; it.by = 13'd6; push_item(it, 0);

    for (int ph = 0; ph < 8; ph++) begin
      push_cfg(CFG_BIN, 24'(ph % 2));
      push_cfg(CFG_DEPTH, 24'(ph % 3));
      push_cfg(CFG_GROW, ph == 7 ? 24'hFFFFFF : ph % 3 == 0 ? 24'd0
                                               : 24'($urandom_range(0, 4096)));
      push_cfg(CFG_COUNT, ph == 0 ? 24'd0 : ph == 5 ? 24'd16
                                          : 24'($urandom_range(1, 4)));
      while (pending.size() != 0) begin
        @(posedge clk);
      end
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      add_random_phase(ph == 5 ? 40 : 160);
    end
    while (pending.size() != 0 || s_tvalid) @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d input transactions and %0d pixels over 8 register settings,",
             sent, pixels_seen);
    $display("with binning on and off, all depths and several idle and stall mixes.");
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("simulation failed");
    $finish;
  end

endmodule
